// ===== hw/rtl/integer_to_radix_digits_macros.svh =====
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH

// overlapping implication
`define ITRD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// next-cycle implication
`define ITRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/itrd_pkg.sv =====
package itrd_pkg;

  localparam int VAL_W     = 64;
  localparam int DIG_W     = 4;
  localparam int CHAR_W    = 8;
  localparam int NUM_CHARS = 16;
  localparam int BASE_W    = 5;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_DIGITS_DEF = 64;
  localparam int MAX_BASE_DEF   = 16;

  localparam logic [BASE_W-1:0] BASE_RST = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_SIZE  = 2'd0,
    REG_CHARS_LOW  = 2'd1,
    REG_CHARS_HIGH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic start;
    logic cont;
  } div_ctrl_t;

  typedef struct packed {
    logic             done;
    logic [DIG_W-1:0] digit;
    logic             q_zero;
  } div_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

endpackage

// ===== hw/rtl/itrd_div.sv =====
module itrd_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  itrd_pkg::div_ctrl_t                 ctrl,
  input  logic [itrd_pkg::VAL_W-1:0]          dividend,
  input  logic [itrd_pkg::BASE_W-1:0]         radix,
  output itrd_pkg::div_stat_t                 stat
);
  import itrd_pkg::*;

  localparam int CNT_W = $clog2(VAL_W);

  logic [VAL_W-1:0]  quo_r;
  logic [DIG_W-1:0]  rem_r;
  logic [BASE_W-1:0] radix_r;
  logic [CNT_W-1:0]  bit_cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              nz_r;

  logic [BASE_W-1:0] trial;
  logic [BASE_W-1:0] diff;
  logic              ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_r, quo_r[VAL_W-1]};
    ge    = (trial >= radix_r);
    diff  = trial - radix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start || ctrl.cont) begin
        if (ctrl.start) begin
          quo_r   <= dividend;
          radix_r <= radix;
        end
        rem_r     <= '0;
        bit_cnt_r <= '0;
        nz_r      <= 1'b0;
        busy_r    <= 1'b1;
      end else if (busy_r) begin
        quo_r     <= {quo_r[VAL_W-2:0], ge};
        rem_r     <= ge ? diff[DIG_W-1:0] : trial[DIG_W-1:0];
        nz_r      <= nz_r | ge;
        bit_cnt_r <= bit_cnt_r + CNT_W'(1);
        if (bit_cnt_r == CNT_W'(VAL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.done   = done_r;
  assign stat.digit  = rem_r;
  assign stat.q_zero = !nz_r;

endmodule

// ===== hw/rtl/itrd_stack.sv =====
module itrd_stack #(
  parameter int DEPTH = itrd_pkg::MAX_DIGITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  itrd_pkg::stk_ctrl_t               ctrl,
  input  logic [itrd_pkg::DIG_W-1:0]        din,
  output logic [itrd_pkg::DIG_W-1:0]        top,
  output logic [$clog2(DEPTH+1)-1:0]        count
);
  import itrd_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [DIG_W-1:0] stk_r [DEPTH];
  logic [CW-1:0]    count_r;

  // shift line: push moves entries up, pop moves them down
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      stk_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        stk_r[i] <= stk_r[i-1];
      end
    end else if (ctrl.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.push) begin
      count_r <= count_r + CW'(1);
    end else if (ctrl.pop) begin
      count_r <= count_r - CW'(1);
    end
  end

  assign top   = stk_r[0];
  assign count = count_r;

endmodule

// ===== hw/rtl/integer_to_radix_digits.sv =====
// channel | direction | handshake            | payload
// cfg     | in        | cfg_we               | cfg_index, cfg_wdata
// in      | in        | in_valid / in_ready  | in_value, in_is_signed
// out     | out       | out_valid / out_ready| out_digit_char, out_last_digit
//
// each digit comes from the bit-serial divider (one quotient bit per cycle
// plus a handoff), an item yields up to MAX_DIGITS digits, then one digit per
// cycle is delivered while out_ready is high; one item is in work at a time
// reset is synchronous on rst_n low; base_size returns to 10, tables to zero
// out_ready low holds a valid output register and stops popping digits
module integer_to_radix_digits #(
  parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF,
  parameter int MAX_BASE   = itrd_pkg::MAX_BASE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [itrd_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [itrd_pkg::VAL_W-1:0]        in_value,
  input  logic                              in_is_signed,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [itrd_pkg::CHAR_W-1:0]       out_digit_char,
  output logic                              out_last_digit
);
  import itrd_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [BASE_W-1:0] base_size_r;
  logic [CFG_W-1:0]  chars_low_r;
  logic [CFG_W-1:0]  chars_high_r;

  logic                  out_valid_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic                  out_last_r;

  logic [BASE_W-1:0]     radix_eff;
  logic [VAL_W-1:0]      magnitude;
  logic                  accept;
  logic                  finish;
  logic                  load_out;
  logic                  is_last;
  div_ctrl_t             div_ctrl;
  div_stat_t             div_stat;
  stk_ctrl_t             stk_ctrl;
  logic [DIG_W-1:0]      stk_top;
  logic [CW-1:0]         stk_count;
  logic [NUM_CHARS-1:0][CHAR_W-1:0] char_tab;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_size_r  <= BASE_RST;
      chars_low_r  <= '0;
      chars_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_SIZE:  base_size_r  <= cfg_wdata[BASE_W-1:0];
        REG_CHARS_LOW:  chars_low_r  <= cfg_wdata;
        REG_CHARS_HIGH: chars_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (base_size_r < BASE_MIN) begin
      radix_eff = BASE_MIN;
    end else if (base_size_r > BASE_W'(MAX_BASE)) begin
      radix_eff = BASE_W'(MAX_BASE);
    end else begin
      radix_eff = base_size_r;
    end
  end

  assign magnitude = (in_is_signed && in_value[VAL_W-1]) ? (VAL_W'(0) - in_value) : in_value;
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign finish    = div_stat.q_zero || (stk_count == CW'(MAX_DIGITS - 1));
  assign load_out  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign is_last   = (stk_count == CW'(1));

  assign div_ctrl.start = accept;
  assign div_ctrl.cont  = (state_r == ST_DIV) && div_stat.done && !finish;
  assign stk_ctrl.push  = (state_r == ST_DIV) && div_stat.done;
  assign stk_ctrl.pop   = load_out;

  assign char_tab = {chars_high_r, chars_low_r};

  itrd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (magnitude),
    .radix    (radix_eff),
    .stat     (div_stat)
  );

  itrd_stack #(
    .DEPTH (MAX_DIGITS)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (stk_ctrl),
    .din   (div_stat.digit),
    .top   (stk_top),
    .count (stk_count)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done && finish) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (load_out && is_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
        out_char_r  <= char_tab[stk_top];
        out_last_r  <= is_last;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

endmodule

// ===== hw/rtl/itrd_checker.sv =====
`include "integer_to_radix_digits_macros.svh"

module itrd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [itrd_pkg::CHAR_W-1:0] out_digit_char,
  input logic                        out_last_digit
);

  `ITRD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  `ITRD_ASSERT_SAME(a_min_digit_time, in_valid && in_ready, ##64 !in_ready, "item finished too early")

  `ITRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_digit_char) && $stable(out_last_digit), "stalled item changed")

  `ITRD_ASSERT_SAME(a_no_input_mid_item, out_valid && !out_last_digit, !in_ready, "input ready before last digit")

endmodule

bind integer_to_radix_digits itrd_checker u_itrd_checker (.*);
